FILE: hdl/tnc_pkg.sv
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared types, constants and the note lookup tables of the tuner note
// classifier. The tables are built by constant functions at elaboration.
// ----------------------------------------------------------------------------
package tnc_pkg;

   // sizes
   localparam int NUM_ENTRIES = 19;
   localparam int NUM_STEPS   = 15;
   localparam int CENTER_STEP = 7;
   localparam int FOLD_SHIFTS = 10;

   typedef logic [23:0]        freq_type;
   typedef logic [15:0]        age_type;
   typedef logic [14:0]        fold_type;
   typedef logic [4:0]         entry_idx_type;
   typedef logic [3:0]         step_idx_type;
   typedef logic [3:0]         class_type;
   typedef logic signed [3:0]  dev_type;
   typedef logic [NUM_STEPS-1:0][14:0] thresh_row_type;

   // controller commands to the datapath
   typedef struct packed {
      logic load;
      logic classify;
      logic emit;
   } dp_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASS,
      ST_DEV
   } ctrl_state_type;

   localparam age_type  STALE_LIMIT_RESET = 16'd500;
   // f >> k stays above 110 Hz (28160 in Q8) exactly when f >= 28161 << k
   localparam freq_type FOLD_EDGE_BASE    = 24'd28161;

   localparam logic [63:0] RATIO_NUM  = 64'd100828;
   localparam logic [63:0] RATIO_DEN  = 64'd100000;
   localparam logic [63:0] Q40_ONE    = 64'd1 << 40;
   localparam logic [63:0] THRESH_DEN = 64'd1000 << 32;
   localparam logic [63:0] BOUND_DEN  = 64'd10000;

   // semitone bases in mHz, D# up to A
   localparam logic [16:0] ENTRY_BASE_MILLI [NUM_ENTRIES] = '{
      17'd38891,  17'd41203,  17'd43654,  17'd46249,  17'd48999,
      17'd51913,  17'd55000,  17'd58270,  17'd61735,  17'd65406,
      17'd69296,  17'd73416,  17'd77782,  17'd82407,  17'd87307,
      17'd92499,  17'd97999,  17'd103826, 17'd110000};

   // upper bounds in units of 0.1 mHz
   localparam logic [20:0] ENTRY_MAX_E4 [NUM_ENTRIES] = '{
      21'd400305,  21'd424103,  21'd449331,  21'd476041,  21'd504347,
      21'd534341,  21'd566116,  21'd599774,  21'd635439,  21'd673225,
      21'd713265,  21'd755672,  21'd800611,  21'd848217,  21'd898652,
      21'd952094,  21'd1008705, 21'd1068683, 21'd1132232};

   localparam class_type ENTRY_CLASS [NUM_ENTRIES] = '{
      4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd0,
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9};

   // Q40 power of 1.00828, stepped out from the center with rounding
   function automatic logic [63:0] pow_q40(input int step);
      logic [63:0] p;
      int          k;
      p = Q40_ONE;
      for (k = CENTER_STEP; k < step; k++) begin
         p = (p * RATIO_NUM + RATIO_DEN / 2) / RATIO_DEN;
      end
      for (k = step; k < CENTER_STEP; k++) begin
         p = (p * RATIO_DEN + RATIO_NUM / 2) / RATIO_NUM;
      end
      return p;
   endfunction

   function automatic fold_type bound_q8(input int e);
      logic [63:0] v;
      v = (64'(ENTRY_MAX_E4[e]) * 64'd256 + BOUND_DEN / 2) / BOUND_DEN;
      return v[14:0];
   endfunction

   function automatic fold_type thresh_q8(input int e, input int s);
      logic [63:0] v;
      v = (64'(ENTRY_BASE_MILLI[e]) * pow_q40(s) + THRESH_DEN / 2) / THRESH_DEN;
      return v[14:0];
   endfunction

   function automatic thresh_row_type thresh_row(input int e);
      thresh_row_type row;
      int             s;
      for (s = 0; s < NUM_STEPS; s++) begin
         row[s] = thresh_q8(e, s);
      end
      return row;
   endfunction

   localparam fold_type ENTRY_BOUND [NUM_ENTRIES] = '{
      bound_q8(0),  bound_q8(1),  bound_q8(2),  bound_q8(3),  bound_q8(4),
      bound_q8(5),  bound_q8(6),  bound_q8(7),  bound_q8(8),  bound_q8(9),
      bound_q8(10), bound_q8(11), bound_q8(12), bound_q8(13), bound_q8(14),
      bound_q8(15), bound_q8(16), bound_q8(17), bound_q8(18)};

   localparam thresh_row_type THRESH_TBL [NUM_ENTRIES] = '{
      thresh_row(0),  thresh_row(1),  thresh_row(2),  thresh_row(3),
      thresh_row(4),  thresh_row(5),  thresh_row(6),  thresh_row(7),
      thresh_row(8),  thresh_row(9),  thresh_row(10), thresh_row(11),
      thresh_row(12), thresh_row(13), thresh_row(14), thresh_row(15),
      thresh_row(16), thresh_row(17), thresh_row(18)};

endpackage

FILE: hdl/tnc_req_if.sv
// ----------------------------------------------------------------------------
// tnc_req_if
// Request channel: one pitch estimate and its age per beat.
// ----------------------------------------------------------------------------
interface tnc_req_if;
   logic              valid;
   logic              ready;
   tnc_pkg::freq_type freq_q8;
   tnc_pkg::age_type  sample_age;

   modport source (output valid, output freq_q8, output sample_age, input ready);
   modport sink   (input valid, input freq_q8, input sample_age, output ready);
endinterface

FILE: hdl/tnc_rsp_if.sv
// ----------------------------------------------------------------------------
// tnc_rsp_if
// Response channel: note class and tuning deviation per beat.
// ----------------------------------------------------------------------------
interface tnc_rsp_if;
   logic               valid;
   logic               ready;
   logic               valid_res;
   tnc_pkg::freq_type  freq_out;
   tnc_pkg::class_type note_class;
   tnc_pkg::dev_type   deviation;

   modport source (output valid, output valid_res, output freq_out,
                   output note_class, output deviation, input ready);
   modport sink   (input valid, input valid_res, input freq_out,
                   input note_class, input deviation, output ready);
endinterface

FILE: hdl/tuner_note_classifier.sv
// ----------------------------------------------------------------------------
// tuner_note_classifier
// Turns a pitch estimate into a pitch class and a tuning deviation.
//
//   port    dir  kind         beat contents
//   req_if  in   valid/ready  freq_q8 (Q16.8 Hz), sample_age
//   rsp_if  out  valid/ready  valid_res, freq_out, note_class, deviation
//   csr_*   in   write only   stale_limit (reset 500)
//
// Each item steps through accept with fold, entry search, and deviation
// search with the write into the response register. The sequencer handles
// one item at a time: no request beat is taken until that write is done.
// The response register lets the next request be taken while a beat waits;
// a stalled response holds the sequencer in its last step until taken.
// Reset is synchronous, active high; stale_limit returns to 500.
// ----------------------------------------------------------------------------
module tuner_note_classifier (
   input  logic             clock,
   input  logic             reset,
   tnc_req_if.sink          req_if,
   tnc_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  tnc_pkg::age_type csr_wdata
);

   tnc_pkg::dp_cmd_type cmd;

   // sequencer
   tnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   // arithmetic and payload
   tnc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .req_freq_q8    (req_if.freq_q8),
      .req_sample_age (req_if.sample_age),
      .rsp_valid_res  (rsp_if.valid_res),
      .rsp_freq_out   (rsp_if.freq_out),
      .rsp_note_class (rsp_if.note_class),
      .rsp_deviation  (rsp_if.deviation)
   );

endmodule

FILE: hdl/tnc_ctrl.sv
// ----------------------------------------------------------------------------
// tnc_ctrl
// Sequencer: steps one item through load, classify and deviation/emit, and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module tnc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tnc_pkg::dp_cmd_type cmd
);

   tnc_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    slot_free;

   // output register can take a new beat
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tnc_pkg::ST_IDLE: begin
            if (req_valid) state_in = tnc_pkg::ST_CLASS;
         end
         tnc_pkg::ST_CLASS: begin
            state_in = tnc_pkg::ST_DEV;
         end
         tnc_pkg::ST_DEV: begin
            if (slot_free) state_in = tnc_pkg::ST_IDLE;
         end
         default: begin
            state_in = tnc_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = (state_ff == tnc_pkg::ST_IDLE);
      cmd.load     = (state_ff == tnc_pkg::ST_IDLE) && req_valid;
      cmd.classify = (state_ff == tnc_pkg::ST_CLASS);
      cmd.emit     = (state_ff == tnc_pkg::ST_DEV) && slot_free;
   end

   // response valid: set on emit, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tnc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/tnc_datapath.sv
// ----------------------------------------------------------------------------
// tnc_datapath
// Stale check and octave fold, semitone entry search, deviation step search
// and the response payload register. Holds the stale limit register.
// ----------------------------------------------------------------------------
module tnc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  tnc_pkg::age_type    csr_wdata,
   input  tnc_pkg::dp_cmd_type cmd,
   input  tnc_pkg::freq_type   req_freq_q8,
   input  tnc_pkg::age_type    req_sample_age,
   output logic                rsp_valid_res,
   output tnc_pkg::freq_type   rsp_freq_out,
   output tnc_pkg::class_type  rsp_note_class,
   output tnc_pkg::dev_type    rsp_deviation
);

   tnc_pkg::age_type         stale_limit_ff;
   tnc_pkg::freq_type        freq_ff;
   logic                     stale_ff;
   tnc_pkg::fold_type        fold_ff, fold_in;
   tnc_pkg::entry_idx_type   entry_ff, entry_in;
   logic                     found_ff, found_in;

   logic                     valid_res_ff;
   tnc_pkg::freq_type        freq_out_ff;
   tnc_pkg::class_type       note_class_ff, note_class_in;
   tnc_pkg::dev_type         deviation_ff, deviation_in;

   logic [tnc_pkg::FOLD_SHIFTS-1:0] over;
   logic [3:0]                      shift;
   tnc_pkg::freq_type               shifted;
   tnc_pkg::thresh_row_type         row;
   tnc_pkg::step_idx_type           step;
   logic                            step_hit;

   // stale limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         stale_limit_ff <= tnc_pkg::STALE_LIMIT_RESET;
      end else if (csr_we) begin
         stale_limit_ff <= csr_wdata;
      end
   end

   // octave fold: shift count is the number of edges the input reaches
   always_comb begin
      for (int k = 0; k < tnc_pkg::FOLD_SHIFTS; k++) begin
         over[k] = (req_freq_q8 >= (tnc_pkg::FOLD_EDGE_BASE << k));
      end
      shift   = 4'($countones(over));
      shifted = req_freq_q8 >> shift;
      fold_in = shifted[14:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         freq_ff  <= req_freq_q8;
         stale_ff <= (req_sample_age >= stale_limit_ff);
         fold_ff  <= fold_in;
      end
   end

   // first semitone entry whose upper bound exceeds the folded value
   always_comb begin
      entry_in = '0;
      found_in = 1'b0;
      for (int e = tnc_pkg::NUM_ENTRIES - 1; e >= 0; e--) begin
         if (fold_ff < tnc_pkg::ENTRY_BOUND[e]) begin
            entry_in = 5'(e);
            found_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         entry_ff <= entry_in;
         found_ff <= found_in;
      end
   end

   // first deviation step whose threshold exceeds the folded value
   always_comb begin
      row      = tnc_pkg::THRESH_TBL[entry_ff];
      step     = '0;
      step_hit = 1'b0;
      for (int s = tnc_pkg::NUM_STEPS - 1; s >= 0; s--) begin
         if (fold_ff < row[s]) begin
            step     = 4'(s);
            step_hit = 1'b1;
         end
      end
      // stale item or no entry: zero class and deviation
      if (stale_ff || !found_ff) begin
         note_class_in = '0;
         deviation_in  = '0;
      end else begin
         note_class_in = tnc_pkg::ENTRY_CLASS[entry_ff];
         if (step_hit) begin
            deviation_in = tnc_pkg::dev_type'(step - 4'(tnc_pkg::CENTER_STEP));
         end else begin
            deviation_in = '0;
         end
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         valid_res_ff  <= !stale_ff;
         freq_out_ff   <= stale_ff ? '0 : freq_ff;
         note_class_ff <= note_class_in;
         deviation_ff  <= deviation_in;
      end
   end

   assign rsp_valid_res  = valid_res_ff;
   assign rsp_freq_out   = freq_out_ff;
   assign rsp_note_class = note_class_ff;
   assign rsp_deviation  = deviation_ff;

endmodule
